/* rtl/hbcs_pkg.sv */
// Package with shared constants, types and state encoding for the collision statistics block.
package hbcs_pkg;

    localparam int MaxTable   = 128;
    localparam int KeyBits    = 20;
    localparam int CountBits  = 16;
    localparam int IdxBits    = $clog2(MaxTable);
    localparam int SizeBits   = 8;
    localparam int SumBits    = 24;
    localparam int AccBits    = 48;
    localparam int VarBits    = 40;
    localparam int SizeReset  = 97;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_WR,
        ST_SCAN1,
        ST_MEAN,
        ST_SCAN2,
        ST_VAR,
        ST_CLEAR,
        ST_OUT,
        ST_INIT
    } state_t;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic [AccBits-1:0] dividend;
        logic [SizeBits-1:0] divisor;
    } div_req_t;

    // Clamp the configured size into the legal range.
    function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] s);
        logic [SizeBits-1:0] r;
        r = s;
        if (s < SizeBits'(2)) r = SizeBits'(2);
        if (s > SizeBits'(MaxTable)) r = SizeBits'(MaxTable);
        return r;
    endfunction

endpackage

/* rtl/hbcs_div.sv */
// Restoring divider that retires one quotient bit per cycle, shared by hash, mean and variance.
module hbcs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hbcs_pkg::div_req_t            req,
    output logic                          busy,
    output logic [hbcs_pkg::AccBits-1:0]  quotient,
    output logic [hbcs_pkg::SizeBits-1:0] remainder
);
    localparam int CntBits = $clog2(hbcs_pkg::AccBits + 1);

    logic [hbcs_pkg::AccBits-1:0]  quot_reg, quot_next;
    logic [hbcs_pkg::SizeBits:0]   rem_reg, rem_next;
    logic [hbcs_pkg::SizeBits-1:0] dvs_reg, dvs_next;
    logic [CntBits-1:0]            cnt_reg, cnt_next;
    logic [hbcs_pkg::SizeBits:0]   trial;

    // One shift and subtract step per cycle.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg[hbcs_pkg::SizeBits-1:0], quot_reg[hbcs_pkg::AccBits-1]};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CntBits'(hbcs_pkg::AccBits);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[hbcs_pkg::AccBits-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[hbcs_pkg::AccBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntBits'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy      = (cnt_reg != '0) || req.start;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[hbcs_pkg::SizeBits-1:0];

    // The remainder always stays below the divisor once a division is running.
    a_rem_small: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && cnt_reg != CntBits'(hbcs_pkg::AccBits)) |-> rem_reg < {1'b0, dvs_reg})
        else $error("divider remainder out of range");
    // A start loads the counter with the full quotient width in the next cycle.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> cnt_reg == CntBits'(hbcs_pkg::AccBits))
        else $error("divider did not start");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && !req.start) |=> cnt_reg == $past(cnt_reg) - CntBits'(1))
        else $error("divider count skipped");
endmodule

/* rtl/hash_bucket_collision_stats.sv */
// Top level of the modulo hash histogram with collision statistics.
// For each accepted key the shared restoring divider retires one of 48 quotient bits
// per cycle to form key mod table_size, then the bucket is read and written back,
// and the block is ready again. A key marked last then costs two walks over
// table_size buckets, two more divider passes for mean and variance, one squaring
// per bucket through a single multiplier, and a clearing sweep over all 128
// buckets before the result is offered; the next key is taken the cycle after
// the result transfer. The bucket store is one memory with one write and one
// read port. After reset a clearing pass over all 128 buckets runs before the
// first key is accepted.
module hash_bucket_collision_stats (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hbcs_pkg::SizeBits-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hbcs_pkg::KeyBits-1:0]  s_key,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_min_collisions,
    output logic signed [16:0]            m_max_collisions,
    output logic signed [16:0]            m_mean_collisions,
    output logic [hbcs_pkg::VarBits-1:0]  m_variance
);
    localparam int IB = hbcs_pkg::IdxBits;
    localparam int CB = hbcs_pkg::CountBits;

    hbcs_pkg::state_t state_reg, state_next;
    logic [hbcs_pkg::SizeBits-1:0] size_reg;
    logic [hbcs_pkg::SizeBits-1:0] m_eff;
    logic                          last_reg;
    logic [IB:0]                   idx_reg, idx_next;
    logic [IB-1:0]                 bucket_reg;
    logic [CB-1:0]                 mem [hbcs_pkg::MaxTable];
    logic [CB-1:0]                 rd_reg;
    logic                          rd_ok_reg;
    logic signed [CB:0]            mn_reg, mx_reg, mean_reg;
    logic signed [hbcs_pkg::SumBits-1:0] sum_reg;
    logic [hbcs_pkg::AccBits-1:0]  acc_reg;
    logic [2*CB+3:0]               sq_reg;
    logic                          sq_ok_reg;
    logic                          first_reg;
    hbcs_pkg::div_req_t            dreq;
    logic                          dbusy;
    logic [hbcs_pkg::AccBits-1:0]  dquot;
    logic [hbcs_pkg::SizeBits-1:0] drem;
    logic                          dstarted_reg;
    logic signed [CB:0]            cval;
    logic signed [CB+1:0]          dev;
    logic [CB+1:0]                 adev;
    logic                          s_xfer, m_xfer;
    logic [hbcs_pkg::SumBits-1:0]  sum_abs;
    logic [hbcs_pkg::SumBits-1:0]  mean_abs;

    assign m_eff  = hbcs_pkg::eff_size(size_reg);
    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;
    assign s_ready = (state_reg == hbcs_pkg::ST_IDLE);
    assign m_valid = (state_reg == hbcs_pkg::ST_OUT);
    assign cval    = $signed({1'b0, rd_reg}) - (CB+1)'(1);
    assign dev     = (CB+2)'(cval) - (CB+2)'(mean_reg);
    assign adev    = dev[CB+1] ? (CB+2)'(-dev) : (CB+2)'(dev);
    assign sum_abs = sum_reg[hbcs_pkg::SumBits-1] ? -sum_reg : sum_reg;

    hbcs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (dreq),
        .busy      (dbusy),
        .quotient  (dquot),
        .remainder (drem)
    );

    // Divider requests from the sequencer.
    always_comb begin
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = m_eff;
        if (s_xfer) begin
            dreq.start    = 1'b1;
            dreq.dividend = hbcs_pkg::AccBits'(s_key);
        end else if (state_reg == hbcs_pkg::ST_MEAN && !dstarted_reg) begin
            dreq.start    = 1'b1;
            dreq.dividend = hbcs_pkg::AccBits'(sum_abs);
        end else if (state_reg == hbcs_pkg::ST_VAR && !dstarted_reg) begin
            dreq.start    = 1'b1;
            dreq.dividend = acc_reg;
            dreq.divisor  = m_eff - hbcs_pkg::SizeBits'(1);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hbcs_pkg::ST_IDLE:  if (s_xfer) state_next = hbcs_pkg::ST_MOD;
            hbcs_pkg::ST_MOD:   if (!dbusy) state_next = hbcs_pkg::ST_RD;
            hbcs_pkg::ST_RD:    state_next = hbcs_pkg::ST_WR;
            hbcs_pkg::ST_WR:    state_next = last_reg ? hbcs_pkg::ST_SCAN1 : hbcs_pkg::ST_IDLE;
            hbcs_pkg::ST_SCAN1: if (rd_ok_reg && idx_reg == (IB+1)'(m_eff))
                                    state_next = hbcs_pkg::ST_MEAN;
            hbcs_pkg::ST_MEAN:  if (dstarted_reg && !dbusy) state_next = hbcs_pkg::ST_SCAN2;
            hbcs_pkg::ST_SCAN2: if (sq_ok_reg && !rd_ok_reg && idx_reg == (IB+1)'(m_eff))
                                    state_next = hbcs_pkg::ST_VAR;
            hbcs_pkg::ST_VAR:   if (dstarted_reg && !dbusy) state_next = hbcs_pkg::ST_CLEAR;
            hbcs_pkg::ST_CLEAR: if (idx_reg == (IB+1)'(hbcs_pkg::MaxTable - 1))
                                    state_next = hbcs_pkg::ST_OUT;
            hbcs_pkg::ST_OUT:   if (m_xfer) state_next = hbcs_pkg::ST_IDLE;
            hbcs_pkg::ST_INIT:  if (idx_reg == (IB+1)'(hbcs_pkg::MaxTable - 1))
                                    state_next = hbcs_pkg::ST_IDLE;
            default:            state_next = hbcs_pkg::ST_IDLE;
        endcase
    end

    // Walk index for scans and clearing.
    always_comb begin
        idx_next = idx_reg;
        case (state_reg)
            hbcs_pkg::ST_SCAN1, hbcs_pkg::ST_SCAN2: begin
                if (idx_reg < (IB+1)'(m_eff)) idx_next = idx_reg + (IB+1)'(1);
            end
            hbcs_pkg::ST_CLEAR, hbcs_pkg::ST_INIT: idx_next = idx_reg + (IB+1)'(1);
            default:            idx_next = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hbcs_pkg::ST_INIT;
            size_reg     <= hbcs_pkg::SizeBits'(hbcs_pkg::SizeReset);
            idx_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            sq_ok_reg    <= 1'b0;
            dstarted_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) size_reg <= cfg_wdata;
            idx_reg   <= idx_next;
            rd_ok_reg <= (state_reg == hbcs_pkg::ST_SCAN1 || state_reg == hbcs_pkg::ST_SCAN2)
                         && idx_reg < (IB+1)'(m_eff);
            sq_ok_reg <= (state_reg == hbcs_pkg::ST_SCAN2) && rd_ok_reg;
            dstarted_reg <= (state_next == state_reg) && (dreq.start || dstarted_reg)
                            && !s_xfer;
        end
    end

    // Bucket memory: one write and one read per cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == hbcs_pkg::ST_WR) begin
            mem[bucket_reg] <= (rd_reg == {CB{1'b1}}) ? rd_reg : rd_reg + CB'(1);
        end else if (state_reg inside {hbcs_pkg::ST_CLEAR, hbcs_pkg::ST_INIT}) begin
            mem[idx_reg[IB-1:0]] <= '0;
        end
        if (state_reg == hbcs_pkg::ST_RD) begin
            rd_reg <= mem[bucket_reg];
        end else if (idx_reg < (IB+1)'(hbcs_pkg::MaxTable)) begin
            rd_reg <= mem[idx_reg[IB-1:0]];
        end
    end

    // Datapath: bucket address, statistics accumulators and squaring.
    assign mean_abs = dquot[hbcs_pkg::SumBits-1:0];
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            last_reg  <= s_last;
            first_reg <= 1'b1;
        end
        if (state_reg == hbcs_pkg::ST_MOD && !dbusy) bucket_reg <= drem[IB-1:0];
        if (state_reg == hbcs_pkg::ST_WR) begin
            sum_reg <= '0;
            acc_reg <= '0;
        end
        if (state_reg == hbcs_pkg::ST_SCAN1 && rd_ok_reg) begin
            first_reg <= 1'b0;
            if (first_reg || cval < mn_reg) mn_reg <= cval;
            if (first_reg || cval > mx_reg) mx_reg <= cval;
            sum_reg <= sum_reg + hbcs_pkg::SumBits'(cval);
        end
        if (state_reg == hbcs_pkg::ST_MEAN && dstarted_reg && !dbusy) begin
            mean_reg <= sum_reg[hbcs_pkg::SumBits-1] ? (CB+1)'(-mean_abs) : (CB+1)'(mean_abs);
        end
        if (state_reg == hbcs_pkg::ST_SCAN2) begin
            sq_reg <= (2*CB+4)'(adev) * (2*CB+4)'(adev);
            if (sq_ok_reg) acc_reg <= acc_reg + hbcs_pkg::AccBits'(sq_reg);
        end
    end

    // Result outputs, driven from the statistics registers and the divider quotient.
    assign m_min_collisions  = mn_reg[CB] ? 16'd0 : mn_reg[15:0];
    assign m_max_collisions  = mx_reg;
    assign m_mean_collisions = mean_reg;
    assign m_variance        = (dquot[hbcs_pkg::AccBits-1:hbcs_pkg::VarBits] != '0)
                               ? {hbcs_pkg::VarBits{1'b1}} : dquot[hbcs_pkg::VarBits-1:0];

    // No new key while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while result pending");
    // A key transfer always starts the divider.
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == hbcs_pkg::ST_MOD)
        else $error("key transfer not followed by hashing");
    // The result stays up until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_variance))
        else $error("result dropped");
endmodule

/* tb/tb_hash_bucket_collision_stats.sv */
// Testbench for the modulo hash histogram with collision statistics.
module tb_hash_bucket_collision_stats;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit  = 6000;
    localparam int SettleTicks = 120;
    localparam int DrainTicks  = 800;

    typedef struct packed {
        logic [15:0]        min_c;
        logic signed [16:0] max_c;
        logic signed [16:0] mean_c;
        logic [39:0]        spread;
    } stats_t;

    typedef struct {
        int        cfg;      // negative means no register write before this key
        bit [19:0] key;
        bit        last;
        bit        typed;
        stats_t    want;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [hbcs_pkg::SizeBits-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [hbcs_pkg::KeyBits-1:0] s_key;
    logic              s_last;
    logic              m_valid;
    logic              m_ready;
    logic [15:0]       m_min_collisions;
    logic signed [16:0] m_max_collisions;
    logic signed [16:0] m_mean_collisions;
    logic [hbcs_pkg::VarBits-1:0] m_variance;

    hash_bucket_collision_stats dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_key(s_key), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_min_collisions(m_min_collisions), .m_max_collisions(m_max_collisions),
        .m_mean_collisions(m_mean_collisions), .m_variance(m_variance)
    );

    // Shadow copy of the bucket store and the size register.
    int unsigned hit_count[hbcs_pkg::MaxTable];
    logic [7:0]  size_reg;
    stats_t      pending_stats[$];
    int          errors;
    int          keys_sent;
    int          reports_seen;
    int          cfg_writes;
    int          idle_ticks;
    int          burst_left;
    int          ready_mode;
    int          ready_tick;

    always #10 aclk = ~aclk;

    function automatic int clamp_size(logic [7:0] s);
        if (s < 2) return 2;
        if (s > hbcs_pkg::MaxTable) return hbcs_pkg::MaxTable;
        return int'(s);
    endfunction

    // Count one key; on the last key of a set return the statistics and clear.
    function automatic bit bucket_key(bit [19:0] key, bit last, output stats_t st);
        int m;
        int b;
        longint c;
        longint mn;
        longint mx;
        longint sum;
        longint avg;
        longint d;
        longint unsigned acc;
        longint unsigned q;
        m = clamp_size(size_reg);
        b = key % m;
        if (hit_count[b] < 65535) hit_count[b]++;
        st = '0;
        if (!last) return 0;
        mn = 0; mx = 0; sum = 0; acc = 0;
        for (int i = 0; i < m; i++) begin
            c = longint'(hit_count[i]) - 1;
            if (i == 0 || c < mn) mn = c;
            if (i == 0 || c > mx) mx = c;
            sum += c;
        end
        avg = sum / m;
        for (int i = 0; i < m; i++) begin
            d = longint'(hit_count[i]) - 1 - avg;
            acc += longint'(d * d);
        end
        q = acc / (m - 1);
        if (q > 64'hFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF;
        if (mn < 0) mn = 0;
        st.min_c  = mn[15:0];
        st.max_c  = mx[16:0];
        st.mean_c = avg[16:0];
        st.spread = q[39:0];
        for (int i = 0; i < hbcs_pkg::MaxTable; i++) hit_count[i] = 0;
        return 1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d (report %0d)",
                 field, got, want, reports_seen);
        errors++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_stats.size() == 0) begin
                $display("unexpected result transfer (report %0d)", reports_seen);
                errors++;
            end else begin
                stats_t w;
                w = pending_stats.pop_front();
                if (m_min_collisions !== w.min_c)
                    report_mismatch("min", m_min_collisions, w.min_c);
                if (m_max_collisions !== w.max_c)
                    report_mismatch("max", m_max_collisions, w.max_c);
                if (m_mean_collisions !== w.mean_c)
                    report_mismatch("mean", m_mean_collisions, w.mean_c);
                if (m_variance !== w.spread)
                    report_mismatch("variance", m_variance, w.spread);
            end
        end
    end

    // Receiver stall pattern: always ready, coin flip, or one cycle in four.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 97 == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= (ready_tick % 4 == 0);
            end
        endcase
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_ticks <= 0;
        end else begin
            idle_ticks <= idle_ticks + 1;
            if (idle_ticks >= WatchLimit) begin
                $display("watchdog expired");
                $display("FAIL");
                $finish;
            end
        end
    end

    // Let the block finish any key in flight, then write the size register.
    task automatic write_size(logic [7:0] v);
        s_valid <= 1'b0;
        wait (pending_stats.size() == 0);
        repeat (SettleTicks) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_reg = v;
        cfg_writes++;
    endtask

    // Send one key in bursts with random gaps; predict at the transfer.
    task automatic send_key(bit [19:0] key, bit last, bit typed, stats_t want);
        stats_t st;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_key   <= key;
        s_last  <= last;
        do @(posedge aclk); while (!s_ready);
        keys_sent++;
        if (bucket_key(key, last, st)) pending_stats.push_back(typed ? want : st);
    endtask

    stats_t none_st;
    stats_t one_hit;
    row_t   rows[$];
    int     set_len;
    int     m_now;
    bit [19:0] k;

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_key = '0;
        s_last = 1'b0;
        m_ready = 1'b0;
        errors = 0;
        keys_sent = 0;
        reports_seen = 0;
        cfg_writes = 0;
        idle_ticks = 0;
        burst_left = 0;
        ready_mode = 0;
        ready_tick = 0;
        size_reg = 8'(hbcs_pkg::SizeReset);
        for (int i = 0; i < hbcs_pkg::MaxTable; i++) hit_count[i] = 0;
        none_st = '0;
        // A single key in an otherwise empty table: min 0, max 0, mean 0, variance 1.
        one_hit = '{min_c: 0, max_c: 0, mean_c: 0, spread: 1};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset size, extreme keys, collisions, clamped sizes, mid-set change.
        rows.push_back('{-1, 20'd0, 1, 1, one_hit});
        rows.push_back('{-1, 20'hFFFFF, 1, 1, one_hit});
        rows.push_back('{-1, 20'd5, 0, 0, none_st});
        rows.push_back('{-1, 20'd102, 0, 0, none_st});
        rows.push_back('{-1, 20'd199, 0, 0, none_st});
        rows.push_back('{-1, 20'd296, 1, 0, none_st});
        rows.push_back('{2, 20'd0, 0, 0, none_st});
        rows.push_back('{-1, 20'd1, 0, 0, none_st});
        rows.push_back('{-1, 20'd2, 0, 0, none_st});
        rows.push_back('{-1, 20'd3, 1, 1, '{min_c: 1, max_c: 1, mean_c: 1, spread: 0}});
        rows.push_back('{0, 20'd7, 1, 1, one_hit});
        rows.push_back('{1, 20'hFFFFF, 1, 0, none_st});
        rows.push_back('{255, 20'd127, 1, 1, one_hit});
        rows.push_back('{200, 20'd128, 0, 0, none_st});
        rows.push_back('{-1, 20'd0, 0, 0, none_st});
        rows.push_back('{128, 20'd1, 0, 0, none_st});
        rows.push_back('{-1, 20'd129, 0, 0, none_st});
        rows.push_back('{3, 20'd4, 0, 0, none_st});
        rows.push_back('{-1, 20'h55555, 0, 0, none_st});
        rows.push_back('{-1, 20'hAAAAA, 1, 0, none_st});
        foreach (rows[i]) begin
            if (rows[i].cfg >= 0) write_size(rows[i].cfg[7:0]);
            send_key(rows[i].key, rows[i].last, rows[i].typed, rows[i].want);
        end

        // Random part: sets of keys, sizes changed between sets.
        while (keys_sent < 820) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 4))
                    0: write_size(8'd2);
                    1: write_size(8'd128);
                    2: write_size(8'($urandom_range(0, 255)));
                    default: write_size(8'($urandom_range(2, 128)));
                endcase
            end
            m_now = clamp_size(size_reg);
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 15);
            for (int j = 0; j < set_len; j++) begin
                case ($urandom_range(0, 3))
                    0: k = 20'($urandom_range(0, 20'hFFFFF));
                    1: k = 20'($urandom_range(0, 3 * m_now));
                    default: k = 20'($urandom_range(0, 3) + m_now * $urandom_range(0, 8191));
                endcase
                send_key(k, j == set_len - 1, 1'b0, none_st);
            end
        end
        s_valid <= 1'b0;

        wait (pending_stats.size() == 0);
        repeat (DrainTicks) @(posedge aclk);

        $display("Sent %0d keys over %0d size settings; checked %0d statistics reports.",
                 keys_sent, cfg_writes + 1, reports_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/hbcs_pkg.sv
rtl/hbcs_div.sv
rtl/hash_bucket_collision_stats.sv
tb/tb_hash_bucket_collision_stats.sv
